### design/nalg_pkg.sv
// ----------------------------------------------------------------------------
// nalg_pkg
// Shared types, constants and helper functions for the normalized associated
// Legendre evaluator.
// ----------------------------------------------------------------------------
package nalg_pkg;

    // One in unsigned Q2.62
    localparam logic [63:0] ONE62      = 64'h4000_0000_0000_0000;
    // 1/(4*pi) with 40 fraction bits
    localparam logic [44:0] INV4PI_Q40 = 45'd87496355274;
    // Saturation limit of recurrence magnitudes
    localparam logic [38:0] VCAP       = '1;

    // Product right-shift amounts
    localparam logic [5:0] SH_NONE = 6'd0;
    localparam logic [5:0] SH_F24  = 6'd24;
    localparam logic [5:0] SH_X30  = 6'd30;
    localparam logic [5:0] SH_K42  = 6'd42;
    localparam logic [5:0] SH_Q62  = 6'd62;

    // Last iteration indices of the divide and square-root unit
    localparam logic [6:0] DIV_LAST  = 7'd63;
    localparam logic [6:0] SQRT_LAST = 7'd31;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  sh;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic        sqrt_mode;
        logic [63:0] num;
        logic [31:0] den;
    } t_ds_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_ds_rsp;

    // Saturate a magnitude to VCAP and apply a sign
    function automatic logic signed [40:0] f_cap_sgn(input logic [63:0] mag, input logic neg);
        logic [38:0] m39;
        logic signed [40:0] v;
        m39 = (|mag[63:39]) ? VCAP : mag[38:0];
        v   = $signed({2'b00, m39});
        return neg ? -v : v;
    endfunction

    // Magnitude of a recurrence value
    function automatic logic [39:0] f_mag(input logic signed [40:0] v);
        logic signed [40:0] n;
        n = -v;
        return v[40] ? n[39:0] : v[39:0];
    endfunction

endpackage

### design/nalg_if.sv
// ----------------------------------------------------------------------------
// nalg_in_if / nalg_out_if
// Valid/ready channels for argument items and result items.
// ----------------------------------------------------------------------------
interface nalg_in_if;
    logic        valid;
    logic        ready;
    logic [6:0]  degree;
    logic [6:0]  order;
    logic signed [31:0] arg_x;

    modport source (output valid, output degree, output order, output arg_x, input ready);
    modport sink   (input valid, input degree, input order, input arg_x, output ready);
endinterface

interface nalg_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] value;
    logic        arg_error;

    modport source (output valid, output value, output arg_error, input ready);
    modport sink   (input valid, input value, input arg_error, output ready);
endinterface

### design/nalg_mul.sv
// ----------------------------------------------------------------------------
// nalg_mul
// Shared 64x64 unsigned multiplier: four 32x32 partial products accumulated
// in turn, then a rounding right shift with saturation to 64 bits.
// ----------------------------------------------------------------------------
module nalg_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nalg_pkg::t_mul_req  i_req,
    output nalg_pkg::t_mul_rsp  o_rsp
);
    import nalg_pkg::*;

    logic         r_busy;
    logic         r_done;
    logic [2:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [5:0]   r_sh;
    logic [127:0] r_acc;
    logic [63:0]  r_res;

    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_pp_sh;
    logic [127:0] w_half;
    logic [127:0] w_rnd;
    logic [127:0] w_shr;

    // Select the partial product for this cycle and align it
    always_comb begin
        w_pa = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        w_pb = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        w_pp = 64'(w_pa) * 64'(w_pb);
        case (2'(r_cnt[1]) + 2'(r_cnt[0]))
            2'd0:    w_pp_sh = {64'b0, w_pp};
            2'd1:    w_pp_sh = {32'b0, w_pp, 32'b0};
            default: w_pp_sh = {w_pp, 64'b0};
        endcase
        w_half = (r_sh == SH_NONE) ? 128'd0 : (128'd1 << (r_sh - 6'd1));
        w_rnd  = r_acc + w_half;
        w_shr  = w_rnd >> r_sh;
    end

    // Accumulate, then round and saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_sh   <= i_req.sh;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_cnt[2]) begin
                    r_acc <= r_acc + w_pp_sh;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_res  <= (|w_shr[127:64]) ? '1 : w_shr[63:0];
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

### design/nalg_divsqrt.sv
// ----------------------------------------------------------------------------
// nalg_divsqrt
// Shared restoring divider (64/32, one quotient bit per cycle) and floor
// square root (64-bit radicand, one root bit per cycle) on one subtractor.
// ----------------------------------------------------------------------------
module nalg_divsqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nalg_pkg::t_ds_req  i_req,
    output nalg_pkg::t_ds_rsp  o_rsp
);
    import nalg_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic        r_mode;
    logic [6:0]  r_cnt;
    logic [33:0] r_rem;
    logic [63:0] r_sh;
    logic [31:0] r_root;
    logic [31:0] r_den;

    logic [35:0] w_rn;
    logic [35:0] w_trial;
    logic [35:0] w_diff;
    logic        w_ge;

    // Bring down the next bits and trial-subtract
    always_comb begin
        if (r_mode) begin
            w_rn    = {r_rem, r_sh[63:62]};
            w_trial = {2'b00, r_root, 2'b01};
        end else begin
            w_rn    = {2'b00, r_rem[32:0], r_sh[63]};
            w_trial = {4'b0000, r_den};
        end
        w_ge   = (w_rn >= w_trial);
        w_diff = w_rn - w_trial;
    end

    // Iterate one digit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_mode <= i_req.sqrt_mode;
                r_sh   <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[33:0] : w_rn[33:0];
                if (r_mode) begin
                    r_sh   <= {r_sh[61:0], 2'b00};
                    r_root <= {r_root[30:0], w_ge};
                end else begin
                    r_sh <= {r_sh[62:0], w_ge};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == (r_mode ? SQRT_LAST : DIV_LAST)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_mode ? {32'b0, r_root} : r_sh;

endmodule

### design/normalized_assoc_legendre_eval.sv
// ----------------------------------------------------------------------------
// normalized_assoc_legendre_eval
// Spherical-harmonic-normalized associated Legendre value for degree l,
// order m and Q2.30 argument x, result with 24 fraction bits.
// ----------------------------------------------------------------------------
// Rejected arguments go from the input straight to the output register;
// otherwise the seed loop runs m times and the recurrence l-m-1 times.
// Each seed term costs one divide and two multiplies; each recurrence step
// costs two divides, one square root, two multiplies and one check state.
// Throughput: one item at a time; the next item is taken once the result
// moves to the output register. Reset: sync low.
module normalized_assoc_legendre_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nalg_in_if.sink           i_in,
    nalg_out_if.source        o_out
);
    import nalg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SEED_DIV, S_SEED_M1, S_SEED_M2, S_SCALE, S_SEED_SQRT,
        S_SQ3, S_P1A, S_P1B, S_R_CHK, S_R_DIV, S_R_SQRT, S_R_MX, S_R_SDIV,
        S_R_MF, S_FIN
    } t_state;

    t_state r_state;
    logic   r_issued;
    logic [6:0]  r_l;
    logic [6:0]  r_m;
    logic        r_xneg;
    logic [30:0] r_ax;
    logic [7:0]  r_i;
    logic [63:0] r_pmm;
    logic [62:0] r_omx2;
    logic [62:0] r_ratio;
    logic [63:0] r_q;
    logic [31:0] r_oldf;
    logic [31:0] r_f;
    logic signed [40:0] r_p0;
    logic signed [40:0] r_p1;
    logic signed [40:0] r_a;
    logic signed [40:0] r_b;
    logic signed [40:0] r_res;
    logic        r_err;
    logic        r_ovalid;
    logic [31:0] r_oval;
    logic        r_oerr;

    t_mul_req w_mreq;
    t_mul_rsp w_mrsp;
    t_ds_req  w_dreq;
    t_ds_rsp  w_drsp;

    logic        w_acc;
    logic        w_bad;
    logic [31:0] w_xabs;
    logic [44:0] w_kscale;
    logic [15:0] w_isq;
    logic [15:0] w_msq;
    logic [15:0] w_num;
    logic [15:0] w_den;
    logic signed [40:0] w_t;
    logic [39:0] w_tmag;
    logic [39:0] w_rmag;
    logic [34:0] w_mq;
    logic [31:0] w_val;
    logic signed [40:0] w_sqrt_p0;

    nalg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    nalg_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // Argument check and derived operands
    always_comb begin
        w_acc    = i_in.valid && i_in.ready;
        w_bad    = (i_in.order > i_in.degree) || (i_in.arg_x > 32'sh4000_0000)
                   || (i_in.arg_x < -32'sh4000_0000);
        w_xabs   = i_in.arg_x[31] ? 32'(-i_in.arg_x) : i_in.arg_x;
        w_kscale = 45'({r_m, 1'b1}) * INV4PI_Q40;
        w_isq    = 16'(r_i) * 16'(r_i);
        w_msq    = 16'(r_m) * 16'(r_m);
        w_num    = {w_isq[13:0], 2'b00} - 16'd1;
        w_den    = w_isq - w_msq;
        w_t      = r_a - r_b;
        w_tmag   = f_mag(w_t);
        w_sqrt_p0 = f_cap_sgn(w_drsp.res, r_m[0]);
    end

    // Output rounding: drop 6 fraction bits, round half away from zero, saturate
    always_comb begin
        w_rmag = f_mag(r_res);
        w_mq   = 35'((41'(w_rmag) + 41'd32) >> 6);
        if (r_res[40]) begin
            w_val = (w_mq > 35'h0_8000_0000) ? 32'h8000_0000 : 32'(-w_mq);
        end else begin
            w_val = (w_mq > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w_mq[31:0];
        end
    end

    // Drive the shared units from the current step
    always_comb begin
        w_mreq = '0;
        w_dreq = '0;
        case (r_state)
            S_SQX: begin
                w_mreq.a = {33'b0, r_ax};
                w_mreq.b = {33'b0, r_ax};
                w_mreq.sh = SH_NONE;
                w_mreq.start = !r_issued;
            end
            S_SEED_DIV: begin
                w_dreq.num = ONE62 + 64'(r_i);
                w_dreq.den = {23'b0, r_i, 1'b0};
                w_dreq.start = !r_issued;
            end
            S_SEED_M1: begin
                w_mreq.a = r_pmm;
                w_mreq.b = {1'b0, r_omx2};
                w_mreq.sh = SH_Q62;
                w_mreq.start = !r_issued;
            end
            S_SEED_M2: begin
                w_mreq.a = r_pmm;
                w_mreq.b = {1'b0, r_ratio};
                w_mreq.sh = SH_Q62;
                w_mreq.start = !r_issued;
            end
            S_SCALE: begin
                w_mreq.a = r_pmm;
                w_mreq.b = {19'b0, w_kscale};
                w_mreq.sh = SH_K42;
                w_mreq.start = !r_issued;
            end
            S_SEED_SQRT, S_R_SQRT: begin
                w_dreq.sqrt_mode = 1'b1;
                w_dreq.num = r_q;
                w_dreq.start = !r_issued;
            end
            S_SQ3: begin
                w_dreq.sqrt_mode = 1'b1;
                w_dreq.num = {7'b0, 9'({r_m, 1'b1}) + 9'd2, 48'b0};
                w_dreq.start = !r_issued;
            end
            S_P1A: begin
                w_mreq.a = {24'b0, f_mag(r_p0)};
                w_mreq.b = {32'b0, r_oldf};
                w_mreq.sh = SH_F24;
                w_mreq.start = !r_issued;
            end
            S_P1B: begin
                w_mreq.a = {33'b0, r_ax};
                w_mreq.b = {24'b0, f_mag(r_a)};
                w_mreq.sh = SH_X30;
                w_mreq.start = !r_issued;
            end
            S_R_DIV: begin
                w_dreq.num = {w_num, 48'b0};
                w_dreq.den = {16'b0, w_den};
                w_dreq.start = !r_issued;
            end
            S_R_MX: begin
                w_mreq.a = {33'b0, r_ax};
                w_mreq.b = {24'b0, f_mag(r_p1)};
                w_mreq.sh = SH_X30;
                w_mreq.start = !r_issued;
            end
            S_R_SDIV: begin
                w_dreq.num = {f_mag(r_p0), 24'b0} + {33'b0, r_oldf[31:1]};
                w_dreq.den = r_oldf;
                w_dreq.start = !r_issued && (r_oldf != 32'd0);
            end
            S_R_MF: begin
                w_mreq.a = {24'b0, w_tmag};
                w_mreq.b = {32'b0, r_f};
                w_mreq.sh = SH_F24;
                w_mreq.start = !r_issued;
            end
            default: begin
                w_mreq = '0;
                w_dreq = '0;
            end
        endcase
    end

    // Sequencer: state, working registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // Drop the output once it transfers, unless a new result loads now
            if (r_ovalid && o_out.ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            if (w_mrsp.done || w_drsp.done) begin
                r_issued <= 1'b0;
            end else if (w_mreq.start || w_dreq.start) begin
                r_issued <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_l    <= i_in.degree;
                        r_m    <= i_in.order;
                        r_xneg <= i_in.arg_x[31];
                        r_ax   <= w_xabs[30:0];
                        if (w_bad) begin
                            r_res   <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_err   <= 1'b0;
                            r_state <= S_SQX;
                        end
                    end
                end
                S_SQX: begin
                    if (w_mrsp.done) begin
                        r_omx2  <= ONE62[62:0] - {w_mrsp.res[60:0], 2'b00};
                        r_pmm   <= ONE62;
                        r_i     <= 8'd1;
                        r_state <= (r_m == 7'd0) ? S_SCALE : S_SEED_DIV;
                    end
                end
                S_SEED_DIV: begin
                    if (w_drsp.done) begin
                        r_ratio <= ONE62[62:0] - w_drsp.res[62:0];
                        r_state <= S_SEED_M1;
                    end
                end
                S_SEED_M1: begin
                    if (w_mrsp.done) begin
                        r_pmm   <= w_mrsp.res;
                        r_state <= S_SEED_M2;
                    end
                end
                S_SEED_M2: begin
                    if (w_mrsp.done) begin
                        r_pmm   <= w_mrsp.res;
                        r_i     <= r_i + 8'd1;
                        r_state <= (r_i >= 8'(r_m)) ? S_SCALE : S_SEED_DIV;
                    end
                end
                S_SCALE: begin
                    if (w_mrsp.done) begin
                        r_q     <= w_mrsp.res;
                        r_state <= S_SEED_SQRT;
                    end
                end
                S_SEED_SQRT: begin
                    if (w_drsp.done) begin
                        r_p0  <= w_sqrt_p0;
                        r_res <= w_sqrt_p0;
                        r_state <= (r_l == r_m) ? S_FIN : S_SQ3;
                    end
                end
                S_SQ3: begin
                    if (w_drsp.done) begin
                        r_oldf  <= w_drsp.res[31:0];
                        r_state <= S_P1A;
                    end
                end
                S_P1A: begin
                    if (w_mrsp.done) begin
                        r_a     <= f_cap_sgn(w_mrsp.res, r_p0[40]);
                        r_state <= S_P1B;
                    end
                end
                S_P1B: begin
                    if (w_mrsp.done) begin
                        r_p1    <= f_cap_sgn(w_mrsp.res, r_xneg ^ r_a[40]);
                        r_i     <= 8'(r_m) + 8'd2;
                        r_state <= S_R_CHK;
                    end
                end
                S_R_CHK: begin
                    if (r_i > 8'(r_l)) begin
                        r_res   <= r_p1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_R_DIV;
                    end
                end
                S_R_DIV: begin
                    if (w_drsp.done) begin
                        r_q     <= w_drsp.res;
                        r_state <= S_R_SQRT;
                    end
                end
                S_R_SQRT: begin
                    if (w_drsp.done) begin
                        r_f     <= w_drsp.res[31:0];
                        r_state <= S_R_MX;
                    end
                end
                S_R_MX: begin
                    if (w_mrsp.done) begin
                        r_a     <= f_cap_sgn(w_mrsp.res, r_xneg ^ r_p1[40]);
                        r_state <= S_R_SDIV;
                    end
                end
                S_R_SDIV: begin
                    if (r_oldf == 32'd0) begin
                        r_b     <= '0;
                        r_state <= S_R_MF;
                    end else if (w_drsp.done) begin
                        r_b     <= f_cap_sgn(w_drsp.res, r_p0[40]);
                        r_state <= S_R_MF;
                    end
                end
                S_R_MF: begin
                    if (w_mrsp.done) begin
                        r_p0    <= r_p1;
                        r_p1    <= f_cap_sgn(w_mrsp.res, w_t[40]);
                        r_oldf  <= r_f;
                        r_i     <= r_i + 8'd1;
                        r_state <= S_R_CHK;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= w_val;
                        r_oerr   <= r_err;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.value     = r_oval;
    assign o_out.arg_error = r_oerr;

    // Checks
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.arg_error) |-> (o_out.value == 32'd0))
        else $error("rejected item carries a nonzero value");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mreq.start && w_dreq.start))
        else $error("both shared units started together");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R_CHK) |-> (9'(r_i) <= 9'(r_l) + 9'd1))
        else $error("recurrence index ran past the degree");

endmodule
